### rtl/core/nrtd_pkg.sv
`default_nettype none

package nrtd_pkg;

  localparam int OFF_W  = 19;  // doubled-scale offset, signed
  localparam int SQ_W   = 36;  // one squared offset
  localparam int DSQ_W  = 37;  // squared distance
  localparam int Q_W    = 15;  // direction magnitude, 0..16384
  localparam int ACC_W  = 68;  // normalization accumulators
  localparam int FRAC_SH = 28; // 16384 * 16384 as a shift

  localparam logic [15:0] DIR_ONE  = 16'h4000;
  localparam logic [15:0] DIR_ZERO = 16'h0000;

  typedef struct packed {
    logic signed [OFF_W-1:0] ox;
    logic signed [OFF_W-1:0] oy;
    logic [SQ_W-1:0]         sqx;
    logic [SQ_W-1:0]         sqy;
    logic [DSQ_W-1:0]        dsq;
    logic                    found;
  } nrtd_job_t;

  typedef struct packed {
    logic      push;
    nrtd_job_t job;
  } nrtd_push_t;

endpackage

`default_nettype wire

### rtl/core/nrtd_front.sv
`default_nettype none

module nrtd_front import nrtd_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               accept,
  input  wire logic signed [15:0] shooter_x,
  input  wire logic signed [15:0] shooter_y,
  input  wire logic signed [15:0] target_x,
  input  wire logic signed [15:0] target_y,
  input  wire logic [15:0]        target_width,
  input  wire logic [15:0]        target_height,
  input  wire logic               target_alive,
  input  wire logic               last_target,
  output nrtd_push_t              qpush,
  output logic [1:0]              inflight
);

  // stage 1: offsets
  logic                    s1_valid, s1_alive, s1_last;
  logic signed [OFF_W-1:0] s1_ox, s1_oy;
  // stage 2: squares
  logic                    s2_valid, s2_alive, s2_last;
  logic signed [OFF_W-1:0] s2_ox, s2_oy;
  logic [SQ_W-1:0]         s2_sqx, s2_sqy;
  // running best
  logic                    have_best;
  logic [DSQ_W-1:0]        best_dsq;
  logic signed [OFF_W-1:0] best_ox, best_oy;
  logic [SQ_W-1:0]         best_sqx, best_sqy;

  logic signed [OFF_W-1:0] ox_next, oy_next;
  logic signed [2*OFF_W-1:0] px, py;
  logic [DSQ_W-1:0]        dsq;
  logic                    take;
  nrtd_job_t               upd;

  assign ox_next = $signed({{2{target_x[15]}}, target_x, 1'b0})
                 + $signed({3'b000, target_width})
                 - $signed({{2{shooter_x[15]}}, shooter_x, 1'b0});
  assign oy_next = $signed({{2{target_y[15]}}, target_y, 1'b0})
                 + $signed({3'b000, target_height})
                 - $signed({{2{shooter_y[15]}}, shooter_y, 1'b0});

  assign px = s1_ox * s1_ox;
  assign py = s1_oy * s1_oy;

  always_comb begin
    dsq  = {1'b0, s2_sqx} + {1'b0, s2_sqy};
    take = s2_valid && s2_alive && (dsq != '0) && (!have_best || dsq < best_dsq);
    upd.ox    = take ? s2_ox  : best_ox;
    upd.oy    = take ? s2_oy  : best_oy;
    upd.sqx   = take ? s2_sqx : best_sqx;
    upd.sqy   = take ? s2_sqy : best_sqy;
    upd.dsq   = take ? dsq    : best_dsq;
    upd.found = take || have_best;
  end

  assign qpush    = {s2_valid && s2_last, upd};
  assign inflight = {1'b0, s1_valid && s1_last} + {1'b0, s2_valid && s2_last};

  always_ff @(posedge clk) begin
    s1_ox    <= ox_next;
    s1_oy    <= oy_next;
    s1_alive <= target_alive;
    s1_last  <= last_target;
    s2_ox    <= s1_ox;
    s2_oy    <= s1_oy;
    s2_sqx   <= px[SQ_W-1:0];
    s2_sqy   <= py[SQ_W-1:0];
    s2_alive <= s1_alive;
    s2_last  <= s1_last;
    best_ox  <= upd.ox;
    best_oy  <= upd.oy;
    best_sqx <= upd.sqx;
    best_sqy <= upd.sqy;
    best_dsq <= upd.dsq;
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      have_best <= 1'b0;
    end else begin
      s1_valid <= accept;
      s2_valid <= s1_valid;
      if (s2_valid) begin
        have_best <= s2_last ? 1'b0 : upd.found;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/core/nrtd_queue.sv
`default_nettype none

module nrtd_queue import nrtd_pkg::*; #(
  parameter int DEPTH = 4,
  parameter int CW    = 3
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire nrtd_push_t  wr,
  input  wire logic        rd,
  output nrtd_job_t        head,
  output logic             empty,
  output logic [CW-1:0]    count
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  nrtd_job_t       mem [DEPTH];
  logic [AW-1:0]   wptr, rptr;

  assign empty = (count == '0);
  assign head  = mem[rptr];

  always_ff @(posedge clk) begin
    if (wr.push) begin
      mem[wptr] <= wr.job;
    end
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr.push) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (rd) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      count <= count + CW'(wr.push) - CW'(rd);
    end
  end

endmodule

`default_nettype wire

### rtl/core/nrtd_back.sv
`default_nettype none

module nrtd_back import nrtd_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire nrtd_job_t   head,
  input  wire logic        q_empty,
  output logic             q_pop,
  input  wire logic        pop,
  output logic             empty,
  output logic signed [15:0] dir_x,
  output logic signed [15:0] dir_y,
  output logic             target_found
);

  typedef enum logic [1:0] {IDLE, RUN, FIN} state_t;

  state_t           state;
  logic             out_valid;
  nrtd_job_t        job;
  logic [Q_W-1:0]   mask, qx, qy;
  logic [ACC_W-1:0] d, px, py, ax, ay;
  logic [ACC_W-1:0] rx, ry, trial_x, trial_y;
  logic             acc_x, acc_y;
  logic [15:0]      mx, my;

  // largest q with q*q*dsq <= 2^28*off*off, one bit per cycle:
  // p = q^2*dsq, a = q*dsq*2^(b+1), d = dsq*2^(2b)
  assign rx      = {4'b0, job.sqx, {FRAC_SH{1'b0}}};
  assign ry      = {4'b0, job.sqy, {FRAC_SH{1'b0}}};
  assign trial_x = px + ax + d;
  assign trial_y = py + ay + d;
  assign acc_x   = !qx[Q_W-1] && (trial_x <= rx);
  assign acc_y   = !qy[Q_W-1] && (trial_y <= ry);
  assign mx      = {1'b0, qx};
  assign my      = {1'b0, qy};

  assign q_pop = (state == IDLE) && !q_empty;
  assign empty = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (!q_empty) begin
            job   <= head;
            d     <= {3'b0, head.dsq, {FRAC_SH{1'b0}}};
            px    <= '0;
            py    <= '0;
            ax    <= '0;
            ay    <= '0;
            qx    <= '0;
            qy    <= '0;
            mask  <= {1'b1, {(Q_W-1){1'b0}}};
            state <= RUN;
          end
        end
        RUN: begin
          if (acc_x) begin
            px <= trial_x;
            ax <= (ax >> 1) + d;
            qx <= qx | mask;
          end else begin
            ax <= ax >> 1;
          end
          if (acc_y) begin
            py <= trial_y;
            ay <= (ay >> 1) + d;
            qy <= qy | mask;
          end else begin
            ay <= ay >> 1;
          end
          d    <= d >> 2;
          mask <= mask >> 1;
          if (mask[0]) begin
            state <= FIN;
          end
        end
        FIN: begin
          if (!out_valid || pop) begin
            if (job.found) begin
              dir_x <= job.ox[OFF_W-1] ? 16'(16'd0 - mx) : mx;
              dir_y <= job.oy[OFF_W-1] ? 16'(16'd0 - my) : my;
            end else begin
              dir_x <= DIR_ZERO;
              dir_y <= DIR_ONE;
            end
            target_found <= job.found;
            out_valid    <= 1'b1;
            state        <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/core/nearest_target_direction.sv
// nearest_target_direction
// Input queue side: a target word (box, alive flag, shooter position, last
// mark) is taken on a clock edge with push high and full low. One target
// per cycle is accepted while full is low. Words of one run end with last_target set.
// Result queue side: while empty is low, dir_x/dir_y/target_found hold the
// oldest result; pop high with empty low takes it. One result per run.
// Front: three pipeline stages (offset, square, compare against the best).
// A run's final word passes the offset and square registers, then enters a
// job queue of JOB_DEPTH entries. Back: a bit-serial normalizer, 15
// iterations plus load and finish per run; it takes a new job only once
// it has finished the last. Runs with fewer targets than the back has steps
// per run are limited by the back, and full rises once the job queue and
// in-flight last words fill it.
// A stalled result holds the back after its current run; the front keeps
// accepting until full rises.
// Reset (rst, synchronous): pipeline, job queue, running best and result
// register are emptied; empty reads high, full low.
`default_nettype none

module nearest_target_direction import nrtd_pkg::*; #(
  parameter int JOB_DEPTH = 4
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  output logic                    full,
  input  wire logic signed [15:0] shooter_x,
  input  wire logic signed [15:0] shooter_y,
  input  wire logic signed [15:0] target_x,
  input  wire logic signed [15:0] target_y,
  input  wire logic [15:0]        target_width,
  input  wire logic [15:0]        target_height,
  input  wire logic               target_alive,
  input  wire logic               last_target,
  output logic                    empty,
  input  wire logic               pop,
  output logic signed [15:0]      dir_x,
  output logic signed [15:0]      dir_y,
  output logic                    target_found
);

  localparam int CNT_W = $clog2(JOB_DEPTH + 1);

  nrtd_push_t        qpush;
  nrtd_job_t         head;
  logic [1:0]        inflight;
  logic              q_empty, q_pop;
  logic [CNT_W-1:0]  count;
  logic [CNT_W+1:0]  occupancy;

  assign occupancy = (CNT_W+2)'(count) + (CNT_W+2)'(inflight);
  assign full      = occupancy >= (CNT_W+2)'(JOB_DEPTH);

  nrtd_front u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (push && !full),
    .shooter_x    (shooter_x),
    .shooter_y    (shooter_y),
    .target_x     (target_x),
    .target_y     (target_y),
    .target_width (target_width),
    .target_height(target_height),
    .target_alive (target_alive),
    .last_target  (last_target),
    .qpush        (qpush),
    .inflight     (inflight)
  );

  nrtd_queue #(
    .DEPTH(JOB_DEPTH),
    .CW   (CNT_W)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .wr   (qpush),
    .rd   (q_pop),
    .head (head),
    .empty(q_empty),
    .count(count)
  );

  nrtd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .q_empty     (q_empty),
    .q_pop       (q_pop),
    .pop         (pop),
    .empty       (empty),
    .dir_x       (dir_x),
    .dir_y       (dir_y),
    .target_found(target_found)
  );

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(JOB_DEPTH))
    else $error("job queue overflow");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    (count == CNT_W'(JOB_DEPTH)) |-> !qpush.push || q_pop)
    else $error("job pushed into full queue");

  a_default_dir: assert property (@(posedge clk) disable iff (rst)
    (!empty && !target_found) |-> (dir_x == 16'sd0) && (dir_y == 16'sd16384))
    else $error("bad default direction");

  a_dir_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (dir_x <= 16'sd16384) && (dir_x >= -16'sd16384)
            && (dir_y <= 16'sd16384) && (dir_y >= -16'sd16384))
    else $error("direction out of range");

endmodule

`default_nettype wire
